[rtl/core/bsn_pkg.sv]
// Package: shared types and constants of the byte-order-mark and newline normalizer.
`default_nettype none

package bsn_pkg;

  // Fixed byte codes.
  localparam logic [7:0] MARK0 = 8'hEF;
  localparam logic [7:0] MARK1 = 8'hBB;
  localparam logic [7:0] MARK2 = 8'hBF;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Queue between the classifier and the output serializer.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTRW  = $clog2(QDEPTH);
  localparam int unsigned QCNTW  = $clog2(QDEPTH + 1);

  // Results one input byte can cause, at most.
  localparam int unsigned MAXRES = 3;

  // Progress through a possible byte order mark at stream start.
  typedef enum logic [1:0] {
    MP_START = 2'd0,
    MP_EF    = 2'd1,
    MP_EFBB  = 2'd2,
    MP_DATA  = 2'd3
  } mark_phase_e;

  // All results caused by one input transaction.
  typedef struct packed {
    logic [1:0]                   cnt;     // number of results, 1 to 3
    logic [MAXRES-1:0][7:0]       bytes;   // result bytes, entry 0 first
    logic                         marker;  // single end marker, no byte
    logic                         eos;     // last result closes the stream
  } bsn_bundle_t;

  // Write side of the queue.
  typedef struct packed {
    logic        push;
    bsn_bundle_t bundle;
  } bsn_push_t;

  // Read side of the queue.
  typedef struct packed {
    logic        empty;
    bsn_bundle_t head;
  } bsn_head_t;

endpackage

`default_nettype wire

[rtl/core/bsn_in_if.sv]
// Interface: input channel, one raw byte or end marker per transaction.
`default_nettype none

interface bsn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output has_byte,
                  output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input has_byte,
                  input end_of_stream, output ready);
endinterface

`default_nettype wire

[rtl/core/bsn_out_if.sv]
// Interface: output channel, one normalized byte or end marker per transaction.
`default_nettype none

interface bsn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       run_last;
  logic       stream_done;

  modport source (output valid, output out_byte, output out_valid,
                  output run_last, output stream_done, input ready);
  modport sink   (input valid, input out_byte, input out_valid,
                  input run_last, input stream_done, output ready);
endinterface

`default_nettype wire

[rtl/core/bsn_front.sv]
// Front end: tracks mark and CR state and turns each input byte into a result bundle.
`default_nettype none

module bsn_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              has_byte_i,
  input  logic              end_of_stream_i,
  output bsn_pkg::bsn_push_t push_o
);
  import bsn_pkg::*;

  mark_phase_e mp_q, mp_d, mp_nb;
  logic        cr_q, cr_d, cr_nb;
  logic        plain;

  // Effect of the byte alone, before any end-of-stream flush.
  always_comb begin
    mp_nb = mp_q;
    plain = 1'b0;
    if (has_byte_i) begin
      unique case (mp_q)
        MP_START: begin
          if (data_byte_i == MARK0) mp_nb = MP_EF;
          else begin
            mp_nb = MP_DATA;
            plain = 1'b1;
          end
        end
        MP_EF: begin
          if (data_byte_i == MARK1) mp_nb = MP_EFBB;
          else begin
            mp_nb = MP_DATA;
            plain = 1'b1;
          end
        end
        MP_EFBB: begin
          mp_nb = MP_DATA;
          plain = (data_byte_i != MARK2);
        end
        MP_DATA: plain = 1'b1;
        default: plain = 1'b1;
      endcase
    end
    cr_nb = plain ? (data_byte_i == CH_CR) : cr_q;
  end

  // Next state: end of stream returns to the start state.
  always_comb begin
    if (end_of_stream_i) begin
      mp_d = MP_START;
      cr_d = 1'b0;
    end else begin
      mp_d = mp_nb;
      cr_d = cr_nb;
    end
  end

  // Outputs: build the bundle of results for this transaction.
  always_comb begin
    logic [1:0]             n;
    logic [MAXRES-1:0][7:0] b;
    logic                   marker;
    n      = 2'd0;
    b      = '0;
    marker = 1'b0;
    if (has_byte_i) begin
      unique case (mp_q)
        MP_EF: begin
          if (data_byte_i != MARK1) begin
            b[0] = MARK0;
            n    = 2'd1;
          end
        end
        MP_EFBB: begin
          if (data_byte_i != MARK2) begin
            b[0] = MARK0;
            b[1] = MARK1;
            n    = 2'd2;
          end
        end
        default: ;
      endcase
    end
    if (plain) begin
      if (cr_q) begin
        if (n != 2'd3) b[n] = CH_LF;
        n = n + 2'd1;
      end
      if ((data_byte_i != CH_CR) && !(cr_q && (data_byte_i == CH_LF))) begin
        if (n != 2'd3) b[n] = data_byte_i;
        n = n + 2'd1;
      end
    end
    if (end_of_stream_i) begin
      if (mp_nb == MP_EF) begin
        if (n != 2'd3) b[n] = MARK0;
        n = n + 2'd1;
      end else if (mp_nb == MP_EFBB) begin
        if (n != 2'd3) b[n] = MARK0;
        n = n + 2'd1;
        if (n != 2'd3) b[n] = MARK1;
        n = n + 2'd1;
      end
      if (cr_nb) begin
        if (n != 2'd3) b[n] = CH_LF;
        n = n + 2'd1;
      end
      if (n == 2'd0) begin
        marker = 1'b1;
        n      = 2'd1;
      end
    end
    push_o.push          = accept_i && (n != 2'd0);
    push_o.bundle.cnt    = n;
    push_o.bundle.bytes  = b;
    push_o.bundle.marker = marker;
    push_o.bundle.eos    = end_of_stream_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mp_q <= MP_START;
      cr_q <= 1'b0;
    end else if (accept_i) begin
      mp_q <= mp_d;
      cr_q <= cr_d;
    end
  end

  // A CR is only held once the mark phase is over.
  a_cr_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cr_q |-> (mp_q == MP_DATA))
    else $error("CR held during mark phase");

  // An end of stream always yields at least one result.
  a_eos_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && end_of_stream_i) |-> (push_o.push && push_o.bundle.cnt != 2'd0))
    else $error("end of stream produced no result");

endmodule

`default_nettype wire

[rtl/core/bsn_fifo.sv]
// Queue: short FIFO of result bundles between front end and serializer.
`default_nettype none

module bsn_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsn_pkg::bsn_push_t push_i,
  input  logic               pop_i,
  output logic               full_o,
  output bsn_pkg::bsn_head_t head_o
);
  import bsn_pkg::*;

  bsn_bundle_t            mem_q [QDEPTH];
  logic [QPTRW-1:0]       wr_q, rd_q;
  logic [QCNTW-1:0]       cnt_q;
  logic                   do_push, do_pop;

  assign full_o       = (cnt_q == QCNTW'(QDEPTH));
  assign head_o.empty = (cnt_q == '0);
  assign head_o.head  = mem_q[rd_q];
  assign do_push      = push_i.push && !full_o;
  assign do_pop       = pop_i && !head_o.empty;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_i.bundle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + QPTRW'(1);
      if (do_pop)  rd_q <= rd_q + QPTRW'(1);
      cnt_q <= cnt_q + QCNTW'(do_push) - QCNTW'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push |-> !full_o)
    else $error("push into full queue");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNTW'(QDEPTH))
    else $error("queue fill count out of range");

endmodule

`default_nettype wire

[rtl/core/bsn_back.sv]
// Back end: walks bundles one result per ready cycle into output register.
`default_nettype none

module bsn_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsn_pkg::bsn_head_t head_i,
  output logic               pop_o,
  bsn_out_if.source          out_o
);
  import bsn_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [7:0] byte_q, byte_d;
  logic       ov_q, ov_d;
  logic       last_q, last_d;
  logic       done_q, done_d;
  logic       load, is_last;

  assign load    = !head_i.empty && (!vld_q || out_o.ready);
  assign is_last = (idx_q == head_i.head.cnt - 2'd1);
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q;
    byte_d = byte_q;
    ov_d   = ov_q;
    last_d = last_q;
    done_d = done_q;
    if (!vld_q || out_o.ready) vld_d = !head_i.empty;
    if (load) begin
      byte_d = head_i.head.marker ? 8'h00 : head_i.head.bytes[idx_q];
      ov_d   = !head_i.head.marker;
      last_d = is_last;
      done_d = is_last && head_i.head.eos;
      idx_d  = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    ov_q   <= ov_d;
    last_q <= last_d;
    done_q <= done_d;
  end

  assign out_o.valid       = vld_q;
  assign out_o.out_byte    = byte_q;
  assign out_o.out_valid   = ov_q;
  assign out_o.run_last    = last_q;
  assign out_o.stream_done = done_q;

  // Index into the head bundle stays within its result count.
  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_i.empty |-> (idx_q < head_i.head.cnt))
    else $error("serializer index beyond bundle");

endmodule

`default_nettype wire

[rtl/core/bom_strip_newline_normalizer.sv]
// Top level: UTF-8 byte order mark stripper and CR/CRLF to LF normalizer.
`default_nettype none

// Streaming text normalizer, one byte per input transaction. A UTF-8 byte
// order mark (EF BB BF) is dropped only when it forms the first three bytes
// of a stream; a partial mark is passed on as data. CR LF and a lone CR both
// become LF. On end_of_stream any held mark bytes and a held CR are flushed,
// the final result carries stream_done, and the block goes back to its
// start state; an end with nothing to flush gives one end-marker result
// (out_valid 0, out_byte 0). run_last flags the last result of each input
// transaction; inputs that cause no result (a held byte without end) give
// nothing at the output.
// Rate: one input transaction per cycle while the queue has room. The front
// end classifies a byte in the cycle it is accepted and pushes its results
// as one bundle into a four-entry queue; the back end drains one result per
// cycle into the output register while out_o.ready does not stall it. One
// transaction causes at most 3 results, more than 1 only around stream start
// and end or for a CR followed by a byte other than CR or LF. The input
// stalls only when the queue is full.

module bom_strip_newline_normalizer (
  input  logic      clk_i,
  input  logic      rst_ni,
  bsn_in_if.sink    in_i,
  bsn_out_if.source out_o
);
  import bsn_pkg::*;

  bsn_push_t push;
  bsn_head_t head;
  logic      full;
  logic      pop;
  logic      accept;

  // Accept whenever the queue has room; the output side is decoupled.
  assign in_i.ready = !full;
  assign accept     = in_i.valid && !full;

  bsn_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (in_i.data_byte),
    .has_byte_i      (in_i.has_byte),
    .end_of_stream_i (in_i.end_of_stream),
    .push_o          (push)
  );

  bsn_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  bsn_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
